// ===== design/pbst_pkg.sv =====
// ----------------------------------------------------------------------------
// pbst_pkg: shared types and constants of the packet burst statistics tracker
// Holds the raw burst record handed from the front end to the back end.
// ----------------------------------------------------------------------------
package pbst_pkg;

  localparam int LEAD_SLOTS  = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic       CMD_OBSERVE = 1'b0;
  localparam logic       CMD_FLUSH   = 1'b1;

  localparam logic [23:0] GAP_THRESHOLD_RESET = 24'd100000;

  // raw accumulators of one closed burst
  typedef struct packed {
    logic [15:0] burst_pkts;
    logic [31:0] size_sum;
    logic [47:0] size_square_sum;
    logic [15:0] size_lowest;
    logic [15:0] size_highest;
    logic [15:0] outbound_packets;
    logic [39:0] gap_sum;
    logic [63:0] gap_square_sum;
    logic [23:0] gap_lowest;
    logic [23:0] gap_highest;
    logic [63:0] leading_sizes;
  } burst_raw_t;

endpackage

// ===== design/pbst_if.sv =====
// ----------------------------------------------------------------------------
// pbst interfaces: packet, result and configuration channels
// Each channel carries valid, ready and its payload.
// ----------------------------------------------------------------------------
interface pbst_pkt_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] pkt_size;
  logic        is_outbound;
  logic [31:0] timestamp_us;
  modport source (output valid, cmd, pkt_size, is_outbound, timestamp_us, input ready);
  modport sink (input valid, cmd, pkt_size, is_outbound, timestamp_us, output ready);
endinterface

interface pbst_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] burst_pkts;
  logic [31:0] byte_total;
  logic [15:0] size_min;
  logic [15:0] size_max;
  logic [19:0] mean_size_q4;
  logic [19:0] stddev_size_q4;
  logic [15:0] outbound_pkts;
  logic [27:0] mean_gap_q4;
  logic [23:0] min_gap_us;
  logic [23:0] max_gap_us;
  logic [27:0] stddev_gap_q4;
  logic [63:0] first_sizes_packed;
  modport source (output valid, burst_pkts, byte_total, size_min, size_max,
                  mean_size_q4, stddev_size_q4, outbound_pkts, mean_gap_q4,
                  min_gap_us, max_gap_us, stddev_gap_q4, first_sizes_packed,
                  input ready);
  modport sink (input valid, burst_pkts, byte_total, size_min, size_max,
                mean_size_q4, stddev_size_q4, outbound_pkts, mean_gap_q4,
                min_gap_us, max_gap_us, stddev_gap_q4, first_sizes_packed,
                output ready);
endinterface

interface pbst_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] gap_limit_us;
  modport source (output valid, gap_limit_us, input ready);
  modport sink (input valid, gap_limit_us, output ready);
endinterface

// ===== design/pbst_front.sv =====
// ----------------------------------------------------------------------------
// pbst_front: packet classification and burst accumulation
// Accepts one request per cycle while the record queue is not full, closes bursts and pushes raw records.
// ----------------------------------------------------------------------------
module pbst_front #(
  parameter int LEADING_WINDOW    = 4,
  parameter int MAX_BURST_PACKETS = 65535
) (
  input  logic                clk,
  input  logic                rst,
  pbst_pkt_if.sink            pkt,
  pbst_cfg_if.sink            cfg,
  input  logic                q_full,
  output logic                q_push,
  output pbst_pkg::burst_raw_t q_entry
);
  import pbst_pkg::*;

  logic [23:0] thr;
  logic [15:0] cnt;
  logic [31:0] ssum;
  logic [47:0] ssq;
  logic [15:0] smin, smax, ocnt;
  logic [31:0] last_ts;
  logic [39:0] gsum;
  logic [63:0] gsq;
  logic [23:0] gmin, gmax;
  logic [15:0] lead [LEAD_SLOTS];

  logic        take, open, over, full, restart;
  logic [31:0] gap32;
  logic [23:0] gap24;
  logic [15:0] b_cnt, cnt_next, smin_next, smax_next, ocnt_next;
  logic [31:0] ssum_next;
  logic [47:0] ssq_next;
  logic [39:0] gsum_next;
  logic [63:0] gsq_next;
  logic [23:0] gmin_next, gmax_next;
  logic [15:0] lead_next [LEAD_SLOTS];

  assign cfg.ready = 1'b1;
  assign pkt.ready = !q_full;
  assign take      = pkt.valid && pkt.ready;

  // classify the request against the open burst
  assign open    = cnt != 16'd0;
  assign gap32   = pkt.timestamp_us - last_ts;
  assign gap24   = gap32[23:0];
  assign over    = gap32 > {8'd0, thr};
  assign full    = cnt >= 16'(MAX_BURST_PACKETS);
  assign restart = !open || over || full;
  assign q_push  = take && open && (pkt.cmd == CMD_FLUSH || over || full);

  assign q_entry = '{burst_pkts: cnt, size_sum: ssum, size_square_sum: ssq,
                     size_lowest: smin, size_highest: smax, outbound_packets: ocnt,
                     gap_sum: gsum, gap_square_sum: gsq, gap_lowest: gmin,
                     gap_highest: gmax,
                     leading_sizes: {lead[3], lead[2], lead[1], lead[0]}};

  // fold the packet into the open burst or into a fresh one
  always_comb begin
    b_cnt     = restart ? 16'd0 : cnt;
    cnt_next  = b_cnt + 16'd1;
    ssum_next = (restart ? 32'd0 : ssum) + {16'd0, pkt.pkt_size};
    ssq_next  = (restart ? 48'd0 : ssq)
              + {16'd0, {16'd0, pkt.pkt_size} * {16'd0, pkt.pkt_size}};
    smin_next = (restart || pkt.pkt_size < smin) ? pkt.pkt_size : smin;
    smax_next = (restart || pkt.pkt_size > smax) ? pkt.pkt_size : smax;
    ocnt_next = (restart ? 16'd0 : ocnt) + {15'd0, pkt.is_outbound};
    if (restart) begin
      gsum_next = 40'd0;
      gsq_next  = 64'd0;
      gmin_next = 24'hFFFFFF;
      gmax_next = 24'd0;
    end else begin
      gsum_next = gsum + {16'd0, gap24};
      gsq_next  = gsq + {16'd0, {24'd0, gap24} * {24'd0, gap24}};
      gmin_next = gap24 < gmin ? gap24 : gmin;
      gmax_next = gap24 > gmax ? gap24 : gmax;
    end
    for (int i = 0; i < LEAD_SLOTS; i++) begin
      lead_next[i] = restart ? 16'd0 : lead[i];
      if (b_cnt < 16'(LEADING_WINDOW) && b_cnt == 16'(i)) lead_next[i] = pkt.pkt_size;
    end
  end

  // hold the threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= GAP_THRESHOLD_RESET;
    end else if (cfg.valid) begin
      thr <= cfg.gap_limit_us;
    end
  end

  // advance the burst accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; ssum <= '0; ssq <= '0; smin <= 16'hFFFF; smax <= '0; ocnt <= '0;
      last_ts <= '0; gsum <= '0; gsq <= '0; gmin <= 24'hFFFFFF; gmax <= '0;
      for (int i = 0; i < LEAD_SLOTS; i++) lead[i] <= '0;
    end else if (take) begin
      if (pkt.cmd == CMD_FLUSH) begin
        if (open) begin
          cnt <= '0; ssum <= '0; ssq <= '0; smin <= 16'hFFFF; smax <= '0; ocnt <= '0;
          gsum <= '0; gsq <= '0; gmin <= 24'hFFFFFF; gmax <= '0;
          for (int i = 0; i < LEAD_SLOTS; i++) lead[i] <= '0;
        end
      end else begin
        cnt <= cnt_next; ssum <= ssum_next; ssq <= ssq_next;
        smin <= smin_next; smax <= smax_next; ocnt <= ocnt_next;
        last_ts <= pkt.timestamp_us;
        gsum <= gsum_next; gsq <= gsq_next; gmin <= gmin_next; gmax <= gmax_next;
        for (int i = 0; i < LEAD_SLOTS; i++) lead[i] <= lead_next[i];
      end
    end
  end

endmodule

// ===== design/pbst_queue.sv =====
// ----------------------------------------------------------------------------
// pbst_queue: short queue of closed burst records
// Decouples the accumulation front end from the arithmetic back end.
// ----------------------------------------------------------------------------
module pbst_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  pbst_pkg::burst_raw_t push_data,
  input  logic                 pop,
  output logic                 full,
  output logic                 not_empty,
  output pbst_pkg::burst_raw_t head
);
  import pbst_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  burst_raw_t      mem [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [PW:0]     count;

  assign full      = count == (PW+1)'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = mem[rd_ptr];

  // store pushed records
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop)  rd_ptr <= rd_ptr + PW'(1);
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

// ===== design/pbst_back.sv =====
// ----------------------------------------------------------------------------
// pbst_back: feature arithmetic sequencer
// Shared shift-add multiplier, restoring divider and digit square root.
// ----------------------------------------------------------------------------
module pbst_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  pbst_pkg::burst_raw_t q_head,
  output logic                 q_pop,
  pbst_res_if.source           res
);
  import pbst_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_MDIV = 3'd1;
  localparam logic [2:0] PH_MUL1 = 3'd2;
  localparam logic [2:0] PH_MUL2 = 3'd3;
  localparam logic [2:0] PH_VDIV = 3'd4;
  localparam logic [2:0] PH_SQRT = 3'd5;
  localparam logic [2:0] PH_OUT  = 3'd6;

  localparam logic [6:0] DIV_STEPS  = 7'd88;
  localparam logic [6:0] MUL_STEPS  = 7'd64;
  localparam logic [6:0] SQRT_STEPS = 7'd32;

  logic [2:0]  phase;
  logic        sel;
  logic [6:0]  iter;
  burst_raw_t  cur;
  logic [15:0] cnt;
  logic [79:0] mul_acc, mul_a, prod1;
  logic [63:0] mul_b;
  logic [87:0] div_num;
  logic [31:0] div_rem, div_den;
  logic [63:0] quo, sq_v, sq_res, sq_bit;
  logic [19:0] mean_sz, std_sz;
  logic [27:0] mean_gp, std_gp;

  logic        out_valid;
  burst_raw_t  out_raw;
  logic [19:0] out_mean_sz, out_std_sz;
  logic [27:0] out_mean_gp, out_std_gp;

  logic        last, div_ge, sq_ge, n_ge2, n_ge3;
  logic [32:0] div_shift, div_sub;
  logic [31:0] rem_next, vden;
  logic [63:0] quo_final, sq_trial, res_final;
  logic [79:0] mul_sum, diff;
  logic [39:0] s_sel;
  logic [15:0] cnt_m1;

  // shared datapath steps
  always_comb begin
    last      = iter == 7'd1;
    div_shift = {div_rem, div_num[87]};
    div_ge    = div_shift >= {1'b0, div_den};
    div_sub   = div_shift - {1'b0, div_den};
    rem_next  = div_ge ? div_sub[31:0] : div_shift[31:0];
    quo_final = {quo[62:0], div_ge};
    mul_sum   = mul_acc + (mul_b[0] ? mul_a : 80'd0);
    sq_trial  = sq_res + sq_bit;
    sq_ge     = sq_v >= sq_trial;
    res_final = sq_ge ? ((sq_res >> 1) + sq_bit) : (sq_res >> 1);
    s_sel     = sel ? cur.gap_sum : {8'd0, cur.size_sum};
    diff      = (prod1 >= mul_sum) ? (prod1 - mul_sum) : 80'd0;
    cnt_m1    = cnt - 16'd1;
    vden      = {16'd0, cnt} * {16'd0, cnt_m1};
    n_ge2     = cur.burst_pkts >= 16'd2;
    n_ge3     = cur.burst_pkts >= 16'd3;
  end

  assign q_pop = (phase == PH_IDLE) && q_valid;

  // sequence one burst through the arithmetic units
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && res.ready && phase != PH_OUT) out_valid <= 1'b0;
      case (phase)
        PH_IDLE: begin
          if (q_valid) begin
            cur     <= q_head;
            sel     <= 1'b0;
            div_num <= {52'd0, q_head.size_sum, 4'd0};
            div_rem <= '0;
            div_den <= {16'd0, q_head.burst_pkts};
            iter    <= DIV_STEPS;
            phase   <= PH_MDIV;
          end
        end
        PH_MDIV: begin
          div_num <= {div_num[86:0], 1'b0};
          div_rem <= rem_next;
          quo     <= quo_final;
          iter    <= iter - 7'd1;
          if (last) begin
            if (!sel) begin
              mean_sz <= quo_final[19:0];
              sel     <= 1'b1;
              div_num <= {44'd0, cur.gap_sum, 4'd0};
              div_rem <= '0;
              div_den <= {16'd0, cur.burst_pkts - 16'd1};
              iter    <= DIV_STEPS;
            end else begin
              mean_gp <= n_ge2 ? quo_final[27:0] : 28'd0;
              sel     <= 1'b0;
              cnt     <= cur.burst_pkts;
              mul_acc <= '0;
              mul_a   <= {32'd0, cur.size_square_sum};
              mul_b   <= {48'd0, cur.burst_pkts};
              iter    <= MUL_STEPS;
              phase   <= PH_MUL1;
            end
          end
        end
        PH_MUL1, PH_MUL2: begin
          mul_acc <= mul_sum;
          mul_a   <= {mul_a[78:0], 1'b0};
          mul_b   <= {1'b0, mul_b[63:1]};
          iter    <= iter - 7'd1;
          if (last) begin
            if (phase == PH_MUL1) begin
              prod1   <= mul_sum;
              mul_acc <= '0;
              mul_a   <= {40'd0, s_sel};
              mul_b   <= {24'd0, s_sel};
              iter    <= MUL_STEPS;
              phase   <= PH_MUL2;
            end else begin
              div_num <= {diff, 8'd0};
              div_rem <= '0;
              div_den <= vden;
              iter    <= DIV_STEPS;
              phase   <= PH_VDIV;
            end
          end
        end
        PH_VDIV: begin
          div_num <= {div_num[86:0], 1'b0};
          div_rem <= rem_next;
          quo     <= quo_final;
          iter    <= iter - 7'd1;
          if (last) begin
            sq_v   <= quo_final;
            sq_res <= '0;
            sq_bit <= 64'h4000_0000_0000_0000;
            iter   <= SQRT_STEPS;
            phase  <= PH_SQRT;
          end
        end
        PH_SQRT: begin
          if (sq_ge) sq_v <= sq_v - sq_trial;
          sq_res <= res_final;
          sq_bit <= sq_bit >> 2;
          iter   <= iter - 7'd1;
          if (last) begin
            if (!sel) begin
              std_sz  <= n_ge2 ? res_final[19:0] : 20'd0;
              sel     <= 1'b1;
              cnt     <= cur.burst_pkts - 16'd1;
              mul_acc <= '0;
              mul_a   <= {16'd0, cur.gap_square_sum};
              mul_b   <= {48'd0, cur.burst_pkts - 16'd1};
              iter    <= MUL_STEPS;
              phase   <= PH_MUL1;
            end else begin
              std_gp <= n_ge3 ? res_final[27:0] : 28'd0;
              phase  <= PH_OUT;
            end
          end
        end
        PH_OUT: begin
          if (!out_valid || res.ready) begin
            out_valid   <= 1'b1;
            out_raw     <= cur;
            out_mean_sz <= mean_sz;
            out_std_sz  <= std_sz;
            out_mean_gp <= mean_gp;
            out_std_gp  <= std_gp;
            phase       <= PH_IDLE;
          end
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
    end
  end

  // drive the result channel from the output register
  assign res.valid              = out_valid;
  assign res.burst_pkts         = out_raw.burst_pkts;
  assign res.byte_total         = out_raw.size_sum;
  assign res.size_min           = out_raw.size_lowest;
  assign res.size_max           = out_raw.size_highest;
  assign res.mean_size_q4       = out_mean_sz;
  assign res.stddev_size_q4     = out_std_sz;
  assign res.outbound_pkts      = out_raw.outbound_packets;
  assign res.mean_gap_q4        = out_mean_gp;
  assign res.min_gap_us         = (out_raw.burst_pkts >= 16'd2) ? out_raw.gap_lowest : 24'd0;
  assign res.max_gap_us         = (out_raw.burst_pkts >= 16'd2) ? out_raw.gap_highest : 24'd0;
  assign res.stddev_gap_q4      = out_std_gp;
  assign res.first_sizes_packed = out_raw.leading_sizes;

endmodule

// ===== design/packet_burst_statistics_tracker.sv =====
// Sequencing: the back end takes each closed burst through two 88-step
//   divides, then per statistic two 64-step multiplies, an 88-step divide
//   and a 32-step root, plus load and output.
// Throughput: one packet per cycle while the two-entry record queue has room;
//   closed bursts drain one at a time, each only after the last has finished.
// Reset: synchronous, clears the open burst, the queue and the output register.
// ----------------------------------------------------------------------------
// packet_burst_statistics_tracker: top level
// Front end accumulates bursts, back end computes the burst features.
// ----------------------------------------------------------------------------
module packet_burst_statistics_tracker #(
  parameter int LEADING_WINDOW    = 4,
  parameter int MAX_BURST_PACKETS = 65535
) (
  input  logic       clk,
  input  logic       rst,
  pbst_pkt_if.sink   pkt,
  pbst_cfg_if.sink   cfg,
  pbst_res_if.source res
);
  import pbst_pkg::*;

  logic       q_push, q_pop, q_full, q_not_empty;
  burst_raw_t q_entry, q_head;

  pbst_front #(
    .LEADING_WINDOW    (LEADING_WINDOW),
    .MAX_BURST_PACKETS (MAX_BURST_PACKETS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .pkt     (pkt),
    .cfg     (cfg),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  pbst_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_entry),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  pbst_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_not_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule
